### rtl/sws_pkg.sv
// ----------------------------------------------------------------------------
// sws_pkg
// Shared codes, types and defaults of the sliding-window sender.
// ----------------------------------------------------------------------------
package sws_pkg;

    localparam int RING_DEPTH_DEF = 16;
    localparam int SEQ_W          = 32;
    localparam int CFG_DATA_W     = 4;
    localparam logic [3:0] MIF_RESET = 4'd8;

    localparam logic [1:0] OP_NEW  = 2'd0;
    localparam logic [1:0] OP_ACK  = 2'd1;
    localparam logic [1:0] OP_NACK = 2'd2;
    localparam logic [1:0] OP_TICK = 2'd3;

    localparam logic [1:0] KIND_SEND   = 2'd0;
    localparam logic [1:0] KIND_RESEND = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    localparam logic [1:0] CAUSE_NONE    = 2'd0;
    localparam logic [1:0] CAUSE_TIMEOUT = 2'd1;
    localparam logic [1:0] CAUSE_DUPACK  = 2'd2;
    localparam logic [1:0] CAUSE_NACK    = 2'd3;

    localparam logic CFG_SEL_REPEAT = 1'b0;
    localparam logic CFG_MAX_FLIGHT = 1'b1;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_REJ   = 9'b000000010,
        ST_RS_RD = 9'b000000100,
        ST_RS_EV = 9'b000001000,
        ST_RT_RD = 9'b000010000,
        ST_RT_EV = 9'b000100000,
        ST_SD_RD = 9'b001000000,
        ST_SD_EV = 9'b010000000,
        ST_END   = 9'b100000000
    } state_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [SEQ_W-1:0] pkt_seq;
        logic [3:0]       slot;
        logic [1:0]       cause;
        logic [3:0]       retired;
        logic             last;
    } result_t;

endpackage

### rtl/sws_ring.sv
// ----------------------------------------------------------------------------
// sws_ring
// Sequence number ring: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sws_ring #(
    parameter int DEPTH = sws_pkg::RING_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic [sws_pkg::SEQ_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr,
    output logic [sws_pkg::SEQ_W-1:0] rd_data
);
    import sws_pkg::*;

    logic [SEQ_W-1:0] mem [DEPTH];
    logic [SEQ_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/sws_ctrl.sv
// ----------------------------------------------------------------------------
// sws_ctrl
// Window sequencer: walks ring entries one at a time through a shared
// address adder and a shared sequence comparator.
// ----------------------------------------------------------------------------
module sws_ctrl #(
    parameter int DEPTH = sws_pkg::RING_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_addr,
    input  logic [sws_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                          in_valid,
    input  logic [1:0]                    in_op,
    input  logic [sws_pkg::SEQ_W-1:0]     in_seq,
    output logic                          in_ready,
    input  logic                          out_free,
    output logic                          emit,
    output sws_pkg::result_t              emit_word,
    output logic                          mem_we,
    output logic                          mem_re,
    output logic [AW-1:0]                 mem_addr,
    output logic [sws_pkg::SEQ_W-1:0]     mem_wdata,
    input  logic [sws_pkg::SEQ_W-1:0]     mem_rdata
);
    import sws_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SW    = CNT_W + 1;
    localparam int LW    = (CNT_W > 4) ? CNT_W : 4;

    state_t           state_reg, state_next;
    logic [AW-1:0]    oldest_reg, oldest_next;
    logic [CNT_W-1:0] sent_reg, sent_next;
    logic [CNT_W-1:0] queued_reg, queued_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [SEQ_W-1:0] prev_ack_reg, prev_ack_next;
    logic             prev_valid_reg, prev_valid_next;
    logic [SEQ_W-1:0] key_reg, key_next;
    logic [1:0]       op_reg, op_next;
    logic             all_reg, all_next;
    logic [1:0]       cause_reg, cause_next;
    logic [3:0]       retired_reg, retired_next;
    logic             sel_reg;
    logic [3:0]       mif_reg;

    logic [3:0]       limit;
    logic [CNT_W-1:0] offset;
    logic [SW-1:0]    sum;
    logic [AW-1:0]    ptr;
    logic [AW-1:0]    oldest_inc;
    logic             key_eq;
    logic             key_lt;

    // shared address adder: oldest + offset, wrapped once
    always_comb begin
        case (state_reg)
            ST_IDLE:  offset = queued_reg;
            ST_RS_RD,
            ST_RS_EV: offset = idx_reg;
            ST_SD_RD,
            ST_SD_EV: offset = sent_reg;
            default:  offset = '0;
        endcase
        sum = SW'(oldest_reg) + SW'(offset);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        ptr = AW'(sum);
    end

    assign oldest_inc = (oldest_reg == AW'(DEPTH - 1)) ? '0 : oldest_reg + AW'(1);

    // shared comparator
    assign key_eq = (mem_rdata == key_reg);
    assign key_lt = (mem_rdata < key_reg);

    assign limit     = (mif_reg == 4'd0) ? 4'd1 : mif_reg;
    assign in_ready  = (state_reg == ST_IDLE);
    assign mem_addr  = ptr;
    assign mem_wdata = in_seq;

    always_comb begin
        state_next      = state_reg;
        oldest_next     = oldest_reg;
        sent_next       = sent_reg;
        queued_next     = queued_reg;
        idx_next        = idx_reg;
        prev_ack_next   = prev_ack_reg;
        prev_valid_next = prev_valid_reg;
        key_next        = key_reg;
        op_next         = op_reg;
        all_next        = all_reg;
        cause_next      = cause_reg;
        retired_next    = retired_reg;
        emit            = 1'b0;
        emit_word       = '0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    key_next     = in_seq;
                    op_next      = in_op;
                    retired_next = '0;
                    idx_next     = '0;
                    case (in_op)
                        OP_NEW: begin
                            if (queued_reg >= CNT_W'(DEPTH)) begin
                                state_next = ST_REJ;
                            end else begin
                                mem_we      = 1'b1;
                                queued_next = queued_reg + CNT_W'(1);
                                state_next  = ST_SD_RD;
                            end
                        end
                        OP_ACK: begin
                            prev_ack_next   = in_seq;
                            prev_valid_next = 1'b1;
                            if (prev_valid_reg && (in_seq == prev_ack_reg)) begin
                                all_next   = ~sel_reg;
                                cause_next = CAUSE_DUPACK;
                                state_next = ST_RS_RD;
                            end else begin
                                state_next = ST_RT_RD;
                            end
                        end
                        OP_NACK: begin
                            all_next   = 1'b0;
                            cause_next = CAUSE_NACK;
                            state_next = ST_RS_RD;
                        end
                        default: begin
                            all_next   = 1'b1;
                            cause_next = CAUSE_TIMEOUT;
                            state_next = ST_RS_RD;
                        end
                    endcase
                end
            end
            ST_REJ: begin
                if (out_free) begin
                    emit           = 1'b1;
                    emit_word.kind = KIND_REJECT;
                    state_next     = ST_END;
                end
            end
            ST_RS_RD: begin
                if (idx_reg == sent_reg) begin
                    state_next = (op_reg == OP_ACK) ? ST_RT_RD : ST_END;
                end else begin
                    mem_re     = 1'b1;
                    state_next = ST_RS_EV;
                end
            end
            ST_RS_EV: begin
                if (all_reg || key_eq) begin
                    if (out_free) begin
                        emit              = 1'b1;
                        emit_word.kind    = KIND_RESEND;
                        emit_word.pkt_seq = mem_rdata;
                        emit_word.slot    = 4'(ptr);
                        emit_word.cause   = cause_reg;
                        idx_next          = idx_reg + CNT_W'(1);
                        state_next        = ST_RS_RD;
                    end
                end else begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_RS_RD;
                end
            end
            ST_RT_RD: begin
                if (sent_reg == '0) begin
                    state_next = ST_SD_RD;
                end else begin
                    mem_re     = 1'b1;
                    state_next = ST_RT_EV;
                end
            end
            ST_RT_EV: begin
                if (key_lt) begin
                    oldest_next  = oldest_inc;
                    sent_next    = sent_reg - CNT_W'(1);
                    queued_next  = queued_reg - CNT_W'(1);
                    retired_next = retired_reg + 4'd1;
                    state_next   = ST_RT_RD;
                end else begin
                    state_next = ST_SD_RD;
                end
            end
            ST_SD_RD: begin
                if ((sent_reg < queued_reg) && (LW'(sent_reg) < LW'(limit))) begin
                    mem_re     = 1'b1;
                    state_next = ST_SD_EV;
                end else begin
                    state_next = ST_END;
                end
            end
            ST_SD_EV: begin
                if (out_free) begin
                    emit              = 1'b1;
                    emit_word.kind    = KIND_SEND;
                    emit_word.pkt_seq = mem_rdata;
                    emit_word.slot    = 4'(ptr);
                    sent_next         = sent_reg + CNT_W'(1);
                    state_next        = ST_SD_RD;
                end
            end
            ST_END: begin
                if (out_free) begin
                    emit              = 1'b1;
                    emit_word.kind    = KIND_END;
                    emit_word.retired = retired_reg;
                    emit_word.last    = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            oldest_reg     <= '0;
            sent_reg       <= '0;
            queued_reg     <= '0;
            prev_valid_reg <= 1'b0;
            prev_ack_reg   <= '0;
            sel_reg        <= 1'b0;
            mif_reg        <= MIF_RESET;
        end else begin
            state_reg      <= state_next;
            oldest_reg     <= oldest_next;
            sent_reg       <= sent_next;
            queued_reg     <= queued_next;
            prev_valid_reg <= prev_valid_next;
            prev_ack_reg   <= prev_ack_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_SEL_REPEAT: sel_reg <= cfg_wdata[0];
                    CFG_MAX_FLIGHT: mif_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        key_reg     <= key_next;
        op_reg      <= op_next;
        all_reg     <= all_next;
        cause_reg   <= cause_next;
        retired_reg <= retired_next;
    end

endmodule

### rtl/sliding_window_sender_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_sender_unit
// Sender side of a go-back-N / selective-repeat retransmission window.
// ----------------------------------------------------------------------------
// Input words (s_*) carry an operation in tuser (new packet, cumulative ack,
// nack, timeout tick) and a sequence number in tdata. Each input word yields
// zero or more send, resend or reject words on m_*, closed by an end word
// with tlast high that also reports the entries an ack retired.
// Configuration (selective repeat, window limit) is written through
// cfg_wr_en / cfg_addr / cfg_wdata; the user must write it only while the
// unit is idle, and the unit itself does not enforce this.
// Flow: one input word at a time; s_tready is high only while idle.
// Every ring entry examined takes a registered ring read, then a compare
// and emit step; an ack walks its resend (duplicate acks only), retire and
// send passes in turn.
// A stalled m_tready holds the output register and the sequencer waits
// before the next emit. Reset clears the window pointers, counters and
// the duplicate-ack history and restores the default configuration;
// ring contents are left as they are.
// ----------------------------------------------------------------------------
module sliding_window_sender_unit #(
    parameter int RING_DEPTH = sws_pkg::RING_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_addr,
    input  logic [sws_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,  // seq[31:0]
    input  logic [1:0]                    s_tuser,  // op[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [47:0]                   m_tdata,  // pkt_seq[31:0], slot[35:32],
                                                    // cause[37:36], retired[41:38]
    output logic [1:0]                    m_tuser,  // kind[1:0]
    output logic                          m_tlast
);
    import sws_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);

    logic             emit;
    result_t          emit_word;
    logic             out_free;
    logic             mem_we;
    logic             mem_re;
    logic [AW-1:0]    mem_addr;
    logic [SEQ_W-1:0] mem_wdata;
    logic [SEQ_W-1:0] mem_rdata;

    result_t          out_reg;
    logic             m_tvalid_reg;

    sws_ring #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_addr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_addr),
        .rd_data (mem_rdata)
    );

    sws_ctrl #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_op     (s_tuser),
        .in_seq    (s_tdata),
        .in_ready  (s_tready),
        .out_free  (out_free),
        .emit      (emit),
        .emit_word (emit_word),
        .mem_we    (mem_we),
        .mem_re    (mem_re),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    assign out_free = ~m_tvalid_reg | m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg <= emit_word;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, out_reg.retired, out_reg.cause, out_reg.slot, out_reg.pkt_seq};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

endmodule

### bench/sliding_window_sender_unit_tb.sv
// ----------------------------------------------------------------------------
// sliding_window_sender_unit_tb
// Self-checking bench for the sliding-window sender. A window model in the
// bench tracks the ring, the in-flight and queued counts and the ack history,
// and predicts every send, resend, reject and end word for each accepted
// input word. A short directed pass covers the empty window, ring overflow,
// go-back-N and selective-repeat duplicate acks, nacks, timeouts and a
// lowered window limit. Constrained-by-hand random traffic then runs under
// several window settings with random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module sliding_window_sender_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sws_pkg::*;

    localparam int RING        = RING_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int IDLE_SETTLE = 8;
    localparam int END_SETTLE  = 40;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic                  cfg_addr  = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;
    logic [1:0]            s_tuser   = OP_NEW;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [47:0]           m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;

    // window model
    logic [31:0] win_seq [RING];
    logic [3:0]  win_head     = '0;
    logic [3:0]  win_sent     = '0;
    logic [4:0]  win_queued   = '0;
    logic [31:0] last_ack     = '0;
    logic        ack_seen     = 1'b0;
    logic        sel_repeat   = 1'b0;
    logic [3:0]  flight_limit = MIF_RESET;
    result_t     pending_results [$];

    int          gap_pct      = 14;
    int          stall_pct    = 69;
    logic [31:0] next_seq     = '0;
    int          errors       = 0;
    int          words_sent   = 0;
    int          words_rcvd   = 0;
    int          settings_run = 1;
    int          kind_seen [4] = '{0, 0, 0, 0};
    int          cycle_count  = 0;

    sliding_window_sender_unit #(
        .RING_DEPTH(RING)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic void queue_result(logic [1:0] kind, logic [31:0] pseq,
                                         logic [3:0] slot, logic [1:0] cause,
                                         logic [3:0] retired, logic last);
        result_t r;
        r = '{kind, pseq, slot, cause, retired, last};
        pending_results.push_back(r);
    endfunction

    function automatic void send_waiting_words();
        logic [3:0] limit;
        logic [3:0] s;
        limit = (flight_limit == 4'd0) ? 4'd1 : flight_limit;
        while (win_sent < win_queued && win_sent < limit) begin
            s = win_head + win_sent;
            queue_result(KIND_SEND, win_seq[s], s, CAUSE_NONE, 4'd0, 1'b0);
            win_sent++;
        end
    endfunction

    function automatic void resend_words(logic all, logic [31:0] key, logic [1:0] cause);
        logic [3:0] s;
        for (int i = 0; i < win_sent; i++) begin
            s = win_head + 4'(i);
            if (all || win_seq[s] == key)
                queue_result(KIND_RESEND, win_seq[s], s, cause, 4'd0, 1'b0);
        end
    endfunction

    function automatic void predict_words(logic [1:0] op, logic [31:0] seq);
        logic [3:0] retired;
        logic [3:0] idx;
        retired = '0;
        case (op)
            OP_NEW: begin
                if (win_queued >= RING) begin
                    queue_result(KIND_REJECT, '0, '0, CAUSE_NONE, 4'd0, 1'b0);
                end else begin
                    idx = win_head + win_queued[3:0];
                    win_seq[idx] = seq;
                    win_queued++;
                    send_waiting_words();
                end
            end
            OP_ACK: begin
                if (ack_seen && seq == last_ack)
                    resend_words(!sel_repeat, seq, CAUSE_DUPACK);
                last_ack = seq;
                ack_seen = 1'b1;
                while (win_sent > 0 && win_seq[win_head] < seq) begin
                    win_head++;
                    win_sent--;
                    win_queued--;
                    retired++;
                end
                send_waiting_words();
            end
            OP_NACK: resend_words(1'b0, seq, CAUSE_NACK);
            default: resend_words(1'b1, '0, CAUSE_TIMEOUT);
        endcase
        queue_result(KIND_END, '0, '0, CAUSE_NONE, retired, 1'b1);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            words_rcvd++;
            kind_seen[m_tuser]++;
            if (pending_results.size() == 0) begin
                $error("unexpected result word: kind %0d seq %0h", m_tuser, m_tdata[31:0]);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(m_tuser));
                check_field("pkt_seq", want.pkt_seq, m_tdata[31:0]);
                check_field("slot", 32'(want.slot), 32'(m_tdata[35:32]));
                check_field("cause", 32'(want.cause), 32'(m_tdata[37:36]));
                check_field("retired", 32'(want.retired), 32'(m_tdata[41:38]));
                check_field("last", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, pending_results.size());
            $display("sliding_window_sender_unit_tb: FAIL");
            $finish;
        end
    end

    task automatic send_word(logic [1:0] op, logic [31:0] seq);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= seq;
        do @(posedge aclk); while (!s_tready);
        predict_words(op, seq);
        words_sent++;
    endtask

    task automatic wait_idle(int settle);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_reg(logic addr, logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        if (addr == CFG_SEL_REPEAT)
            sel_repeat = value[0];
        else
            flight_limit = value;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_empty_window();
        send_word(OP_TICK, 32'd0);
        send_word(OP_NACK, 32'd7);      // nothing in flight to match
        send_word(OP_ACK, 32'd0);
    endtask

    task automatic test_fill_and_reject();
        for (int i = 0; i < RING - 1; i++)
            send_word(OP_NEW, 32'(i));
        send_word(OP_NEW, 32'hFFFF_FFFF);
        send_word(OP_NEW, 32'd5);       // ring full
    endtask

    task automatic test_gobackn_resends();
        send_word(OP_TICK, 32'd0);
        send_word(OP_ACK, 32'd3);
        send_word(OP_ACK, 32'd3);       // duplicate, resend whole window
        send_word(OP_NACK, 32'd6);
    endtask

    task automatic test_selective_low_limit();
        wait_idle(IDLE_SETTLE);
        write_reg(CFG_SEL_REPEAT, 4'd1);
        write_reg(CFG_MAX_FLIGHT, 4'd0); // limit zero acts as one, below in-flight count
        settings_run++;
        send_word(OP_ACK, 32'd3);
        send_word(OP_ACK, 32'd10);
        send_word(OP_ACK, 32'hFFFF_FFFF);
    endtask

    task automatic test_random_traffic(logic sel, logic [3:0] limit, int count);
        logic [1:0]  op;
        logic [31:0] seq;
        logic [3:0]  idx;
        int          pick;
        wait_idle(IDLE_SETTLE);
        write_reg(CFG_SEL_REPEAT, {3'b000, sel});
        write_reg(CFG_MAX_FLIGHT, limit);
        settings_run++;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 38) begin
                op  = OP_NEW;
                seq = next_seq;
                if ($urandom_range(5) != 0)
                    next_seq++;
            end else if (pick < 62) begin
                op = OP_ACK;
                if (ack_seen && $urandom_range(4) == 0) begin
                    seq = last_ack;
                end else if (win_sent == 0) begin
                    seq = next_seq;
                end else begin
                    idx = win_head + 4'($urandom_range(win_sent - 1));
                    seq = win_seq[idx] + 32'($urandom_range(3) != 0);
                end
            end else if (pick < 74) begin
                op = OP_NACK;
                if (win_sent == 0) begin
                    seq = next_seq;
                end else begin
                    idx = win_head + 4'($urandom_range(win_sent - 1));
                    seq = win_seq[idx];
                end
            end else if (pick < 86) begin
                op  = OP_TICK;
                seq = $urandom;
            end else begin
                op  = 2'($urandom_range(3));
                seq = $urandom;
            end
            send_word(op, seq);
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        wait_idle(IDLE_SETTLE);

        test_empty_window();
        test_fill_and_reject();
        test_gobackn_resends();
        test_selective_low_limit();

        next_seq = $urandom_range(32'h7FFF_FFFF);
        test_random_traffic(1'b0, 4'd15, 55);
        test_random_traffic(1'b1, 4'd1, 55);
        gap_pct   = 69;
        stall_pct = 14;
        test_random_traffic(1'b1, 4'd8, 55);
        test_random_traffic(1'b0, 4'd0, 55);
        gap_pct   = 0;
        stall_pct = 0;
        test_random_traffic(1'b1, 4'd15, 55);
        test_random_traffic(1'b0, 4'($urandom_range(15)), 55);

        wait_idle(END_SETTLE);
        $display("covered %0d input words under %0d window settings, %0d mismatches",
                 words_sent, settings_run, errors);
        $display("checked %0d result words: %0d sends, %0d resends, %0d rejects, %0d ends",
                 words_rcvd, kind_seen[KIND_SEND], kind_seen[KIND_RESEND],
                 kind_seen[KIND_REJECT], kind_seen[KIND_END]);
        if (errors == 0)
            $display("sliding_window_sender_unit_tb: PASS");
        else
            $display("sliding_window_sender_unit_tb: FAIL");
        $finish;
    end

endmodule
